/* src/dkc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dkc_pkg;

   // pixel and coefficient formats
   localparam int PIXEL_BITS    = 16;
   localparam int COEF_BITS     = 8;
   localparam int KROW_BITS     = 3 * COEF_BITS;
   localparam int OUT_BITS      = 28;
   localparam int RSP_DATA_BITS = ((2 * OUT_BITS + 7) / 8) * 8;

   // product and partial sum widths, full precision
   localparam int PROD_BITS = PIXEL_BITS + COEF_BITS + 1;
   localparam int RSUM_BITS = PROD_BITS + 2;
   localparam int TSUM_BITS = PROD_BITS + 4;

   // geometry
   localparam int DIM_BITS      = 13;
   localparam int ROW_BITS      = 12;
   localparam int MAX_HEIGHT    = 4096;
   localparam int MAX_WIDTH_DEF = 4096;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // register port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = KROW_BITS;

   localparam logic [DIM_BITS-1:0]  WIDTH_RESET   = 13'd640;
   localparam logic [DIM_BITS-1:0]  HEIGHT_RESET  = 13'd480;
   localparam logic [KROW_BITS-1:0] KX_ROW0_RESET = 24'h1000F0;
   localparam logic [KROW_BITS-1:0] KX_ROW1_RESET = 24'h2000E0;
   localparam logic [KROW_BITS-1:0] KX_ROW2_RESET = 24'h1000F0;
   localparam logic [KROW_BITS-1:0] KY_ROW0_RESET = 24'hF0E0F0;
   localparam logic [KROW_BITS-1:0] KY_ROW1_RESET = 24'h000000;
   localparam logic [KROW_BITS-1:0] KY_ROW2_RESET = 24'h102010;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_KX_ROW0      = 3'd2,
      CSR_KX_ROW1      = 3'd3,
      CSR_KX_ROW2      = 3'd4,
      CSR_KY_ROW0      = 3'd5,
      CSR_KY_ROW1      = 3'd6,
      CSR_KY_ROW2      = 3'd7
   } dkc_csr_type;

   typedef logic [PIXEL_BITS-1:0] dkc_pixel_type;

   // one full 3x3 window, row-major from the top-left pixel
   typedef struct packed {
      dkc_pixel_type [8:0] pix;
      logic                last;
   } dkc_window_type;

   typedef struct packed {
      logic [2:0][KROW_BITS-1:0] kx;
      logic [2:0][KROW_BITS-1:0] ky;
   } dkc_kernels_type;

   typedef struct packed {
      logic [DIM_BITS-1:0] width;
      logic [DIM_BITS-1:0] height;
   } dkc_geometry_type;

   typedef struct packed {
      logic                 empty;
      logic [QCNT_BITS-1:0] count;
   } dkc_qstat_type;

   // signed coefficient c of a packed kernel row, left coefficient in the low bits
   function automatic logic signed [COEF_BITS-1:0] coef_at(
      input logic [KROW_BITS-1:0] row,
      input int                   c
   );
      return row[c * COEF_BITS +: COEF_BITS];
   endfunction

endpackage

`default_nettype wire

/* src/dkc_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module dkc_front #(
   parameter int MAX_WIDTH = dkc_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [dkc_pkg::PIXEL_BITS-1:0]    req_pixel,
   input  wire dkc_pkg::dkc_geometry_type         geom,
   input  wire dkc_pkg::dkc_qstat_type            qstat,
   output logic                                   push,
   output dkc_pkg::dkc_window_type                push_item
);
   import dkc_pkg::*;

   localparam int ADDR_BITS = $clog2(MAX_WIDTH);
   localparam int WCMP_BITS = ($clog2(MAX_WIDTH + 1) > DIM_BITS) ?
                              $clog2(MAX_WIDTH + 1) : DIM_BITS;

   logic [PIXEL_BITS-1:0] line_a_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] line_b_mem [MAX_WIDTH];

   logic [ADDR_BITS-1:0]  col_ff, col_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_emit_ff;
   logic                  s1_last_ff;
   logic [PIXEL_BITS-1:0] s1_pixel_ff;
   logic [ADDR_BITS-1:0]  s1_addr_ff;
   logic [PIXEL_BITS-1:0] a_rd_ff;
   logic [PIXEL_BITS-1:0] b_rd_ff;
   logic [2:0][2:0][PIXEL_BITS-1:0] win_ff, win_in;

   logic [WCMP_BITS-1:0] width_ext;
   logic [WCMP_BITS-1:0] eff_w;
   logic [DIM_BITS-1:0]  eff_h;
   logic                 fire;
   logic                 row_end;
   logic                 frame_end;
   logic                 emit;

   // clamp geometry into the supported range
   always_comb begin
      width_ext = WCMP_BITS'(geom.width);
      if (width_ext < WCMP_BITS'(3)) begin
         eff_w = WCMP_BITS'(3);
      end else if (width_ext > WCMP_BITS'(MAX_WIDTH)) begin
         eff_w = WCMP_BITS'(MAX_WIDTH);
      end else begin
         eff_w = width_ext;
      end
      if (geom.height < DIM_BITS'(3)) begin
         eff_h = DIM_BITS'(3);
      end else if (geom.height > DIM_BITS'(MAX_HEIGHT)) begin
         eff_h = DIM_BITS'(MAX_HEIGHT);
      end else begin
         eff_h = geom.height;
      end
   end

   // room for this request and the one still in the read stage
   assign req_tready = ({1'b0, qstat.count} + (QCNT_BITS + 1)'(s1_valid_ff))
                       < (QCNT_BITS + 1)'(QUEUE_DEPTH);
   assign fire = req_tvalid && req_tready;

   assign row_end   = (WCMP_BITS'(col_ff) + WCMP_BITS'(1)) >= eff_w;
   assign frame_end = row_end && ((DIM_BITS'(row_ff) + DIM_BITS'(1)) >= eff_h);
   assign emit      = (row_ff >= ROW_BITS'(2)) && (col_ff >= ADDR_BITS'(2));

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      s1_valid_in = fire;
      if (fire) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + ADDR_BITS'(1);
         end
      end
   end

   // slide the window by one column once the line reads are back
   always_comb begin
      win_in = win_ff;
      if (s1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
         end
         win_in[0][2] = b_rd_ff;
         win_in[1][2] = a_rd_ff;
         win_in[2][2] = s1_pixel_ff;
      end
   end

   always_comb begin
      push = s1_valid_ff && s1_emit_ff;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            push_item.pix[r * 3 + c] = win_in[r][c];
         end
      end
      push_item.last = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         s1_emit_ff  <= emit;
         s1_last_ff  <= frame_end;
         s1_pixel_ff <= req_pixel;
         s1_addr_ff  <= col_ff;
      end
      win_ff <= win_in;
   end

   // previous row: read old entry, write new pixel
   always_ff @(posedge clock) begin
      if (fire) begin
         a_rd_ff           <= line_a_mem[col_ff];
         line_a_mem[col_ff] <= req_pixel;
      end
   end

   // row before that: takes over what line a held, written in the cycle after the read
   always_ff @(posedge clock) begin
      if (fire) begin
         b_rd_ff <= line_b_mem[col_ff];
      end
      if (s1_valid_ff) begin
         line_b_mem[s1_addr_ff] <= a_rd_ff;
      end
   end

endmodule

`default_nettype wire

/* src/dkc_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module dkc_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire dkc_pkg::dkc_window_type  push_item,
   input  wire logic                     pop,
   output dkc_pkg::dkc_window_type       head_item,
   output dkc_pkg::dkc_qstat_type        qstat
);
   import dkc_pkg::*;

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   dkc_window_type        entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;

   function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
      return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
   end

   assign head_item   = entry_ff[rd_ptr_ff];
   assign qstat.empty = (count_ff == '0);
   assign qstat.count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

/* src/dkc_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module dkc_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire dkc_pkg::dkc_window_type           head_item,
   input  wire dkc_pkg::dkc_qstat_type            qstat,
   output logic                                   pop,
   input  wire dkc_pkg::dkc_kernels_type          kernels,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [dkc_pkg::RSP_DATA_BITS-1:0]      rsp_tdata,
   output logic                                   rsp_tlast
);
   import dkc_pkg::*;

   // products
   logic                        p_valid_ff, p_valid_in;
   logic signed [PROD_BITS-1:0] p_x_ff [9];
   logic signed [PROD_BITS-1:0] p_y_ff [9];
   logic signed [PROD_BITS-1:0] p_x_in [9];
   logic signed [PROD_BITS-1:0] p_y_in [9];
   logic                        p_last_ff;
   // row sums
   logic                        r_valid_ff, r_valid_in;
   logic signed [RSUM_BITS-1:0] r_x_ff [3];
   logic signed [RSUM_BITS-1:0] r_y_ff [3];
   logic signed [RSUM_BITS-1:0] r_x_in [3];
   logic signed [RSUM_BITS-1:0] r_y_in [3];
   logic                        r_last_ff;
   // totals, also the output register
   logic                        t_valid_ff, t_valid_in;
   logic [OUT_BITS-1:0]         t_x_ff, t_y_ff;
   logic                        t_last_ff;
   logic signed [TSUM_BITS-1:0] tot_x, tot_y;

   logic en_t, en_r, en_p;

   assign en_t = !t_valid_ff || rsp_tready;
   assign en_r = !r_valid_ff || en_t;
   assign en_p = !p_valid_ff || en_r;
   assign pop  = !qstat.empty && en_p;

   assign p_valid_in = en_p ? pop : p_valid_ff;
   assign r_valid_in = en_r ? p_valid_ff : r_valid_ff;
   assign t_valid_in = en_t ? r_valid_ff : t_valid_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            p_x_in[r * 3 + c] = PROD_BITS'(coef_at(kernels.kx[r], c))
                                * PROD_BITS'($signed({1'b0, head_item.pix[r * 3 + c]}));
            p_y_in[r * 3 + c] = PROD_BITS'(coef_at(kernels.ky[r], c))
                                * PROD_BITS'($signed({1'b0, head_item.pix[r * 3 + c]}));
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         r_x_in[r] = RSUM_BITS'(p_x_ff[3 * r]) + RSUM_BITS'(p_x_ff[3 * r + 1])
                     + RSUM_BITS'(p_x_ff[3 * r + 2]);
         r_y_in[r] = RSUM_BITS'(p_y_ff[3 * r]) + RSUM_BITS'(p_y_ff[3 * r + 1])
                     + RSUM_BITS'(p_y_ff[3 * r + 2]);
      end
      tot_x = TSUM_BITS'(r_x_ff[0]) + TSUM_BITS'(r_x_ff[1]) + TSUM_BITS'(r_x_ff[2]);
      tot_y = TSUM_BITS'(r_y_ff[0]) + TSUM_BITS'(r_y_ff[1]) + TSUM_BITS'(r_y_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
         t_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
         r_valid_ff <= r_valid_in;
         t_valid_ff <= t_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         p_x_ff    <= p_x_in;
         p_y_ff    <= p_y_in;
         p_last_ff <= head_item.last;
      end
      if (en_r) begin
         r_x_ff    <= r_x_in;
         r_y_ff    <= r_y_in;
         r_last_ff <= p_last_ff;
      end
      if (en_t) begin
         t_x_ff    <= tot_x[OUT_BITS-1:0];
         t_y_ff    <= tot_y[OUT_BITS-1:0];
         t_last_ff <= r_last_ff;
      end
   end

   assign rsp_tvalid = t_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({t_y_ff, t_x_ff});
   assign rsp_tlast  = t_last_ff;

endmodule

`default_nettype wire

/* src/dual_kernel_conv3x3.sv */
// Two 3x3 correlations (Sobel X and Y after reset) over a raster-order pixel stream.
// Send pixels (unsigned Q8.8) on req_*, row by row; a result pair (signed Q16.12,
// full precision, no saturation) leaves on rsp_* for every window that lies wholly
// inside the image, i.e. one per pixel at row >= 2 and column >= 2, and it belongs
// to the window whose top-left pixel sits two rows up and two columns left.
// rsp_tlast marks the result of the frame's last pixel. Rate: one pixel per clock
// sustained, limited by the single write port of each line buffer, which is used
// once per pixel; a result is offered once its pixel has passed through the line
// buffer read, the window shift and queue, then multiply, row sum and final sum.
// A four-entry queue sits between the window front and the multiply-add back,
// so the input keeps flowing while a result waits; when rsp_tready stays low the
// queue fills and req_tready drops. Geometry and kernels are written through
// csr_* while the block is idle; width is clamped to 3..MAX_WIDTH and height to
// 3..4096. The line buffers need no clearing after reset: every entry is written
// in the first rows before any window reads it.
`timescale 1ns / 1ps
`default_nettype none

module dual_kernel_conv3x3 #(
   parameter int MAX_WIDTH = dkc_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [15:0]                       req_tdata,   // [15:0] pixel
   // result channel
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [dkc_pkg::RSP_DATA_BITS-1:0]      rsp_tdata,   // [27:0] grad_x, [55:28] grad_y
   output logic                                   rsp_tlast,   // frame_last
   // configuration writes
   input  wire logic                              csr_we,
   input  wire logic [dkc_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [dkc_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import dkc_pkg::*;

   // configuration registers
   logic [DIM_BITS-1:0]       width_ff, width_in;
   logic [DIM_BITS-1:0]       height_ff, height_in;
   logic [2:0][KROW_BITS-1:0] kx_ff, kx_in;
   logic [2:0][KROW_BITS-1:0] ky_ff, ky_in;

   dkc_geometry_type geom;
   dkc_kernels_type  kernels;
   dkc_qstat_type    qstat;
   dkc_window_type   push_item;
   dkc_window_type   head_item;
   logic             push;
   logic             pop;

   // register decode; unused bits of a write are dropped
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      kx_in     = kx_ff;
      ky_in     = ky_ff;
      if (csr_we) begin
         case (dkc_csr_type'(csr_addr))
            CSR_IMAGE_WIDTH: begin
               width_in = csr_wdata[DIM_BITS-1:0];
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = csr_wdata[DIM_BITS-1:0];
            end
            CSR_KX_ROW0: begin
               kx_in[0] = csr_wdata[KROW_BITS-1:0];
            end
            CSR_KX_ROW1: begin
               kx_in[1] = csr_wdata[KROW_BITS-1:0];
            end
            CSR_KX_ROW2: begin
               kx_in[2] = csr_wdata[KROW_BITS-1:0];
            end
            CSR_KY_ROW0: begin
               ky_in[0] = csr_wdata[KROW_BITS-1:0];
            end
            CSR_KY_ROW1: begin
               ky_in[1] = csr_wdata[KROW_BITS-1:0];
            end
            CSR_KY_ROW2: begin
               ky_in[2] = csr_wdata[KROW_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         kx_ff     <= {KX_ROW2_RESET, KX_ROW1_RESET, KX_ROW0_RESET};
         ky_ff     <= {KY_ROW2_RESET, KY_ROW1_RESET, KY_ROW0_RESET};
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         kx_ff     <= kx_in;
         ky_ff     <= ky_in;
      end
   end

   assign geom.width  = width_ff;
   assign geom.height = height_ff;
   assign kernels.kx  = kx_ff;
   assign kernels.ky  = ky_ff;

   // front: counters, line buffers and the sliding window
   dkc_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_pixel  (req_tdata[PIXEL_BITS-1:0]),
      .geom       (geom),
      .qstat      (qstat),
      .push       (push),
      .push_item  (push_item)
   );

   // complete windows waiting for the multiply-add
   dkc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .qstat     (qstat)
   );

   // back: 18 products, row sums, totals and the output register
   dkc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_item  (head_item),
      .qstat      (qstat),
      .pop        (pop),
      .kernels    (kernels),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

/* src/dkc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module dkc_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [dkc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input wire logic                              rsp_tlast
);

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // pipeline is empty right after reset
   a_rsp_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // queue is empty right after reset, so requests are taken
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("not ready right after reset");

   // no result can appear right after reset without a request accepted before it
   a_no_early_result: assert property (@(posedge clock)
      reset ##1 !(req_tvalid && req_tready) ##1 1'b1 ##1 1'b1 |-> !rsp_tvalid)
      else $error("result without a request");

endmodule

bind dual_kernel_conv3x3 dkc_checker u_dkc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

/* bench/dual_kernel_conv3x3_tb.sv */
`timescale 1ns / 1ps

module dual_kernel_conv3x3_tb;
   import dkc_pkg::*;

   localparam int RANDOM_PIXELS = 850;
   localparam int DRAIN_CYCLES  = 20;
   localparam int TALL_ROWS     = 40;

   // one gradient pair as it leaves the block
   typedef struct packed {
      logic [OUT_BITS-1:0] grad_x;
      logic [OUT_BITS-1:0] grad_y;
      logic                frame_last;
   } gradient_pair_type;

   // tracks geometry, kernels, line rows and the 3x3 window, and predicts the pairs
   class gradient_scoreboard;
      logic [DIM_BITS-1:0]       width_reg;
      logic [DIM_BITS-1:0]       height_reg;
      logic [2:0][KROW_BITS-1:0] kx;
      logic [2:0][KROW_BITS-1:0] ky;
      dkc_pixel_type             prev_row [MAX_WIDTH_DEF];
      dkc_pixel_type             older_row [MAX_WIDTH_DEF];
      dkc_pixel_type             win [3][3];
      int unsigned               col;
      int unsigned               row;
      gradient_pair_type         expected_grads [$];
      int                        errors;

      function new();
         width_reg  = 13'd640;
         height_reg = 13'd480;
         kx = {24'h1000F0, 24'h2000E0, 24'h1000F0};
         ky = {24'h102010, 24'h000000, 24'hF0E0F0};
         foreach (prev_row[i]) begin
            prev_row[i]  = '0;
            older_row[i] = '0;
         end
         foreach (win[r, c]) win[r][c] = '0;
         col    = 0;
         row    = 0;
         errors = 0;
      endfunction

      function int unsigned eff_width();
         if (width_reg < 3) return 3;
         if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
         return 32'(width_reg);
      endfunction

      function int unsigned eff_height();
         if (height_reg < 3) return 3;
         if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
         return 32'(height_reg);
      endfunction

      function int unsigned frame_pixels();
         return eff_width() * eff_height();
      endfunction

      function int pending();
         return expected_grads.size();
      endfunction

      function void write_reg(dkc_csr_type addr, logic [CSR_DATA_BITS-1:0] value);
         case (addr)
            CSR_IMAGE_WIDTH:  width_reg  = value[DIM_BITS-1:0];
            CSR_IMAGE_HEIGHT: height_reg = value[DIM_BITS-1:0];
            CSR_KX_ROW0:      kx[0] = value;
            CSR_KX_ROW1:      kx[1] = value;
            CSR_KX_ROW2:      kx[2] = value;
            CSR_KY_ROW0:      ky[0] = value;
            CSR_KY_ROW1:      ky[1] = value;
            CSR_KY_ROW2:      ky[2] = value;
            default: ;
         endcase
      endfunction

      // exact correlation, kept to the output width
      function logic [OUT_BITS-1:0] correlate(logic [2:0][KROW_BITS-1:0] k);
         logic signed [COEF_BITS-1:0] coef;
         longint                      sum;
         sum = 0;
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) begin
               coef = k[r][c * COEF_BITS +: COEF_BITS];
               sum += longint'(coef) * longint'(win[r][c]);
            end
         return sum[OUT_BITS-1:0];
      endfunction

      function void note_pixel(dkc_pixel_type pix);
         int unsigned       w;
         int unsigned       h;
         dkc_pixel_type     top;
         dkc_pixel_type     mid;
         bit                row_end;
         bit                frame_end;
         gradient_pair_type pair;
         w   = eff_width();
         h   = eff_height();
         top = older_row[col];
         mid = prev_row[col];
         older_row[col] = mid;
         prev_row[col]  = pix;
         for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
         end
         win[0][2] = top;
         win[1][2] = mid;
         win[2][2] = pix;
         row_end   = (col + 1 >= w);
         frame_end = row_end && (row + 1 >= h);
         if (row >= 2 && col >= 2) begin
            pair.grad_x     = correlate(kx);
            pair.grad_y     = correlate(ky);
            pair.frame_last = frame_end;
            expected_grads.push_back(pair);
         end
         if (row_end) begin
            col = 0;
            row = frame_end ? 0 : row + 1;
         end else begin
            col++;
         end
      endfunction

      function void check_result(logic [RSP_DATA_BITS-1:0] data, logic last);
         gradient_pair_type want;
         if (expected_grads.size() == 0) begin
            $error("unexpected gradient pair: grad_x %0d grad_y %0d",
                   $signed(data[OUT_BITS-1:0]), $signed(data[2*OUT_BITS-1:OUT_BITS]));
            errors++;
            return;
         end
         want = expected_grads.pop_front();
         if (data[OUT_BITS-1:0] !== want.grad_x) begin
            $error("grad_x: expected %0d, got %0d",
                   $signed(want.grad_x), $signed(data[OUT_BITS-1:0]));
            errors++;
         end
         if (data[2*OUT_BITS-1:OUT_BITS] !== want.grad_y) begin
            $error("grad_y: expected %0d, got %0d",
                   $signed(want.grad_y), $signed(data[2*OUT_BITS-1:OUT_BITS]));
            errors++;
         end
         if (last !== want.frame_last) begin
            $error("frame_last: expected %0d, got %0d", want.frame_last, last);
            errors++;
         end
      endfunction
   endclass

   // clock, reset and block inputs, all known from time zero
   logic                              clock;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [15:0]                       req_tdata  = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]          rsp_tdata;
   logic                              rsp_tlast;
   logic                              csr_we     = 1'b0;
   dkc_csr_type                       csr_addr   = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_BITS-1:0]          csr_wdata  = '0;

   gradient_scoreboard grads = new();

   // idling switches, changed per phase so that some phases run back to back
   bit src_idle_on  = 1'b1;
   bit sink_idle_on = 1'b1;

   // corner pixels for the first directed frame
   dkc_pixel_type corner_pixels [9] = '{16'hFFFF, 16'h0000, 16'h8000,
                                        16'h0001, 16'hFFFF, 16'h7FFF,
                                        16'h00FF, 16'hFF00, 16'h5555};

   dual_kernel_conv3x3 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // gap lengths: mostly none, some short, a few long
   function automatic int pick_idle(bit enabled);
      int roll;
      roll = $urandom_range(0, 99);
      if (!enabled || roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // pixels lean toward the ends of the range now and then
   function automatic dkc_pixel_type pick_pixel();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return 16'h0000;
      if (roll == 1) return 16'hFFFF;
      if (roll == 2) return 16'h0001 << $urandom_range(0, 15);
      return PIXEL_BITS'($urandom_range(0, 16'hFFFF));
   endfunction

   // kernel rows: mostly random, sometimes all most-negative, all most-positive or zero
   function automatic logic [KROW_BITS-1:0] pick_kernel_row();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 24'h808080;
      if (roll == 1) return 24'h7F7F7F;
      if (roll == 2) return 24'h000000;
      return KROW_BITS'($urandom());
   endfunction

   // one register write, csr_we is left high for back to back writes
   task automatic csr_write(input dkc_csr_type addr, input logic [CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      grads.write_reg(addr, data);
   endtask

   // full register set, only called while the block is idle
   task automatic load_config(input logic [DIM_BITS-1:0] width,
                              input logic [DIM_BITS-1:0] height,
                              input logic [2:0][KROW_BITS-1:0] kx,
                              input logic [2:0][KROW_BITS-1:0] ky);
      csr_write(CSR_IMAGE_WIDTH, CSR_DATA_BITS'(width));
      csr_write(CSR_IMAGE_HEIGHT, CSR_DATA_BITS'(height));
      csr_write(CSR_KX_ROW0, kx[0]);
      csr_write(CSR_KX_ROW1, kx[1]);
      csr_write(CSR_KX_ROW2, kx[2]);
      csr_write(CSR_KY_ROW0, ky[0]);
      csr_write(CSR_KY_ROW1, ky[1]);
      csr_write(CSR_KY_ROW2, ky[2]);
      csr_we <= 1'b0;
   endtask

   // one pixel request; tvalid stays high when no gap follows
   task automatic send_pixel(input dkc_pixel_type pix);
      int gap;
      gap = pick_idle(src_idle_on);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
      grads.note_pixel(pix);
   endtask

   task automatic stream_pixels(input int count);
      for (int n = 0; n < count; n++) send_pixel(pick_pixel());
      req_tvalid <= 1'b0;
   endtask

   // all pairs back, then an idle wait for pixels that make no pair
   task automatic wait_for_drain();
      while (grads.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // result side: check every accepted pair, then pick tready for the next edge
   initial begin : gradient_sink
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) grads.check_result(rsp_tdata, rsp_tlast);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            stall = pick_idle(sink_idle_on);
         end
      end
   end

   initial begin : stimulus
      int random_sent;
      int frames;
      logic [DIM_BITS-1:0] width;
      logic [DIM_BITS-1:0] height;
      random_sent = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // kernels left at their reset values, width and height written below three
      csr_write(CSR_IMAGE_WIDTH, CSR_DATA_BITS'(0));
      csr_write(CSR_IMAGE_HEIGHT, CSR_DATA_BITS'(2));
      csr_we <= 1'b0;
      foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
      req_tvalid <= 1'b0;
      wait_for_drain();

      // most-negative and most-positive kernels on full-scale pixels
      load_config(13'd3, 13'd3, {3{24'h808080}}, {3{24'h7F7F7F}});
      for (int i = 0; i < 9; i++) send_pixel(16'hFFFF);
      req_tvalid <= 1'b0;
      wait_for_drain();

      // random phases: small whole frames, geometry changes only between frames
      while (random_sent < RANDOM_PIXELS) begin
         width  = DIM_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                          : $urandom_range(3, 24));
         height = DIM_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                          : $urandom_range(3, 10));
         src_idle_on  = ($urandom_range(0, 3) != 0);
         sink_idle_on = ($urandom_range(0, 3) != 0);
         load_config(width, height,
                     {pick_kernel_row(), pick_kernel_row(), pick_kernel_row()},
                     {pick_kernel_row(), pick_kernel_row(), pick_kernel_row()});
         frames = $urandom_range(1, 3);
         stream_pixels(frames * grads.frame_pixels());
         random_sent += frames * grads.frame_pixels();
         wait_for_drain();
      end

      // tallest frame, clamped height; only the top of it is sent
      src_idle_on  = 1'b1;
      sink_idle_on = 1'b1;
      load_config(13'd3, 13'h1FFF,
                  {pick_kernel_row(), pick_kernel_row(), pick_kernel_row()},
                  {pick_kernel_row(), pick_kernel_row(), pick_kernel_row()});
      stream_pixels(3 * TALL_ROWS);
      wait_for_drain();

      if (grads.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // hang guard, several times the slowest legal run
   initial begin : watchdog
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
